/* hw/rtl/npst_pkg.sv */
// Shared types, constants and the arctangent table for the nearest-point steering block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package npst_pkg;

	// Coordinate and angle widths.
	localparam int COORD_W  = 16;
	localparam int ANGLE_W  = 16;
	localparam int DIST_W   = 30;            // squares that can qualify stay below 2**30
	localparam int CORDIC_W = COORD_W + 4;   // headroom for pre-rotation and CORDIC gain

	localparam int CORDIC_STEPS = 16;
	localparam int ITER_W       = $clog2(CORDIC_STEPS + 1);

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_CAPTURE = 3'd0;
	localparam logic [2:0] REG_STOP    = 3'd1;
	localparam logic [2:0] REG_DEADBND = 3'd2;
	localparam logic [2:0] REG_GAIN    = 3'd3;
	localparam logic [2:0] REG_CRUISE  = 3'd4;
	localparam logic [2:0] REG_HEADING = 3'd5;

	// Quarter-turn offsets used by the pre-rotation.
	localparam logic [ANGLE_W-1:0] ANGLE_PLUS_90  = 16'h4000;
	localparam logic [ANGLE_W-1:0] ANGLE_MINUS_90 = 16'hC000;

	typedef struct packed {
		logic [14:0]        capture_radius_mm;
		logic [14:0]        stop_distance_mm;
		logic [14:0]        aim_deadband;
		logic [7:0]         turn_gain_q8;
		logic [11:0]        cruise_speed_mm_s;
		logic [ANGLE_W-1:0] heading;
	} cfg_t;

	// One nearest point handed from the front to the back.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DIST_W-1:0]  dist_sq;
	} cmd_t;

	// round(atan(2^-i) * 65536 / (2*pi))
	function automatic logic [ANGLE_W-1:0] atan_lut(input logic [4:0] idx);
		logic [ANGLE_W-1:0] v;
		unique case (idx)
			5'd0:    v = 16'd8192;
			5'd1:    v = 16'd4836;
			5'd2:    v = 16'd2555;
			5'd3:    v = 16'd1297;
			5'd4:    v = 16'd651;
			5'd5:    v = 16'd326;
			5'd6:    v = 16'd163;
			5'd7:    v = 16'd81;
			5'd8:    v = 16'd41;
			5'd9:    v = 16'd20;
			5'd10:   v = 16'd10;
			5'd11:   v = 16'd5;
			5'd12:   v = 16'd3;
			5'd13:   v = 16'd1;
			5'd14:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/npst_cfg.sv */
// Configuration registers of the steering block behind an APB-style slave port.
// Depends on npst_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module npst_cfg import npst_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capture_radius_mm <= 15'd1000;
			cfg_q.stop_distance_mm  <= 15'd200;
			cfg_q.aim_deadband      <= 15'd3129;
			cfg_q.turn_gain_q8      <= 8'd102;
			cfg_q.cruise_speed_mm_s <= 12'd300;
			cfg_q.heading           <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CAPTURE: cfg_q.capture_radius_mm <= pwdata[14:0];
				REG_STOP:    cfg_q.stop_distance_mm  <= pwdata[14:0];
				REG_DEADBND: cfg_q.aim_deadband      <= pwdata[14:0];
				REG_GAIN:    cfg_q.turn_gain_q8      <= pwdata[7:0];
				REG_CRUISE:  cfg_q.cruise_speed_mm_s <= pwdata[11:0];
				REG_HEADING: cfg_q.heading           <= pwdata[15:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CAPTURE: prdata = PDATA_W'(cfg_q.capture_radius_mm);
			REG_STOP:    prdata = PDATA_W'(cfg_q.stop_distance_mm);
			REG_DEADBND: prdata = PDATA_W'(cfg_q.aim_deadband);
			REG_GAIN:    prdata = PDATA_W'(cfg_q.turn_gain_q8);
			REG_CRUISE:  prdata = PDATA_W'(cfg_q.cruise_speed_mm_s);
			REG_HEADING: prdata = PDATA_W'(cfg_q.heading);
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/npst_front.sv */
// Front part: a point per cycle while full is low; squares distances, keeps the nearest.
// Depends on npst_pkg; hands at most one cmd_t per cloud to the command queue.
`default_nettype none

module npst_front import npst_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic                      last_point,
	output logic                           full,
	input  wire logic [14:0]               capture_radius_mm,
	input  wire logic                      q_full,
	output logic                           q_push,
	output cmd_t                           q_data
);

	logic               v_s1, last_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic               v_s2, last_s2;
	logic [COORD_W-1:0] x_s2, y_s2;
	logic [31:0]        sqx_s2, sqy_s2;

	logic [DIST_W-1:0]  cap_sq_q;
	logic               found_q;
	logic [DIST_W-1:0]  best_d_q;
	logic [COORD_W-1:0] best_x_q, best_y_q;

	logic [COORD_W-1:0] ax, ay;
	logic [31:0]        d;
	logic               qual;
	logic               stall, adv;

	// Magnitudes as unsigned values; the most negative coordinate maps to 2**15.
	assign ax = x_s1[COORD_W-1] ? (~x_s1 + 1'b1) : x_s1;
	assign ay = y_s1[COORD_W-1] ? (~y_s1 + 1'b1) : y_s1;

	assign d    = sqx_s2 + sqy_s2;
	// Strictly nearer only, so the first of equal points is kept.
	assign qual = (d < {2'b00, cap_sq_q}) && (!found_q || (d[DIST_W-1:0] < best_d_q));

	assign stall = v_s2 & last_s2 & q_full;
	assign adv   = ~stall;
	assign full  = stall;

	assign q_push = v_s2 & last_s2 & ~q_full & (found_q | qual);
	always_comb begin
		q_data.x       = qual ? x_s2 : best_x_q;
		q_data.y       = qual ? y_s2 : best_y_q;
		q_data.dist_sq = qual ? d[DIST_W-1:0] : best_d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			found_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			if (v_s2) begin
				if (last_s2) begin
					found_q <= 1'b0;
				end else if (qual) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cap_sq_q <= DIST_W'(capture_radius_mm) * DIST_W'(capture_radius_mm);
		if (adv) begin
			if (push) begin
				x_s1    <= point_x;
				y_s1    <= point_y;
				last_s1 <= last_point;
			end
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			last_s2 <= last_s1;
			sqx_s2  <= 32'(ax) * 32'(ax);
			sqy_s2  <= 32'(ay) * 32'(ay);
			if (v_s2 && !last_s2 && qual) begin
				best_d_q <= d[DIST_W-1:0];
				best_x_q <= x_s2;
				best_y_q <= y_s2;
			end
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (v_s2 && last_s2 && $stable(x_s2) && $stable(y_s2)))
		else $error("front stage two changed while stalled");

	a_push_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (v_s2 && last_s2 && !q_full))
		else $error("command pushed without a closing point");

	a_clear_after_cloud: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && last_s2 && adv) |=> !found_q)
		else $error("nearest point kept across clouds");

endmodule

`default_nettype wire

/* hw/rtl/npst_cmd_fifo.sv */
// Short command queue between the front and the back of the steering block.
// Depends on npst_pkg for cmd_t and the queue depth.
`default_nettype none

module npst_cmd_fifo import npst_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wr_data,
	output logic      full,
	input  wire logic rd,
	output cmd_t      rd_data,
	output logic      empty
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_wr, do_rd;

	assign full    = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr & ~full;
	assign do_rd   = rd & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CMDQ_CNT_W'(CMDQ_DEPTH))
		else $error("command queue count out of range");

	a_no_lost_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full))
		else $error("write into a full command queue");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("command queue count did not follow a write");

endmodule

`default_nettype wire

/* hw/rtl/npst_back.sv */
// Back part: CORDIC bearing of the nearest point, heading error, and the steering result.
// Depends on npst_pkg; reads commands from the queue and holds one result register.
`default_nettype none

module npst_back import npst_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               q_empty,
	input  wire cmd_t               q_data,
	output logic                    q_pop,
	output logic                    res_valid,
	input  wire logic               res_pop,
	output logic signed [15:0]      turn_rate,
	output logic        [11:0]      forward_speed
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ITER,
		S_ERR,
		S_MUL,
		S_DONE
	} state_t;

	state_t                      state_q;
	logic [ITER_W-1:0]           iter_q;
	logic                        res_valid_q;
	logic signed [15:0]          turn_q;
	logic [11:0]                 fwd_q;

	logic signed [CORDIC_W-1:0]  cx_q, cy_q;
	logic [ANGLE_W-1:0]          z_q;
	logic                        near_q;
	logic signed [ANGLE_W-1:0]   err_q;
	logic signed [24:0]          prod_q;
	logic                        inband_q;
	logic [DIST_W-1:0]           stop_sq_q;

	logic signed [CORDIC_W-1:0]  lx, ly, px, py;
	logic [ANGLE_W-1:0]          pz;
	logic                        at_origin;
	logic signed [CORDIC_W-1:0]  xsh, ysh;
	logic [ANGLE_W-1:0]          lut;
	logic [ANGLE_W-1:0]          mag;
	logic signed [24:0]          rnd;
	logic signed [16:0]          scaled;
	logic signed [15:0]          sat;
	logic                        load_res;

	// Pre-rotation moves the left half plane into the right one.
	assign lx        = CORDIC_W'($signed(q_data.x));
	assign ly        = CORDIC_W'($signed(q_data.y));
	assign at_origin = (q_data.x == '0) && (q_data.y == '0);
	always_comb begin
		px = lx;
		py = ly;
		pz = '0;
		if (lx < 0) begin
			if (ly >= 0) begin
				px = ly;
				py = -lx;
				pz = ANGLE_PLUS_90;
			end else begin
				px = -ly;
				py = lx;
				pz = ANGLE_MINUS_90;
			end
		end
	end

	assign xsh = cx_q >>> iter_q;
	assign ysh = cy_q >>> iter_q;
	assign lut = atan_lut(5'(iter_q));

	assign mag    = err_q[ANGLE_W-1] ? (~err_q + 1'b1) : err_q;
	assign rnd    = prod_q + 25'sd128;
	assign scaled = rnd[24:8];
	always_comb begin
		if (scaled > 17'sd32767) begin
			sat = 16'sh7FFF;
		end else if (scaled < -17'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = scaled[15:0];
		end
	end

	assign q_pop         = (state_q == S_IDLE) && !q_empty;
	assign load_res      = !res_valid_q || res_pop;
	assign res_valid     = res_valid_q;
	assign turn_rate     = turn_q;
	assign forward_speed = fwd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			res_valid_q <= 1'b0;
			turn_q      <= '0;
			fwd_q       <= '0;
		end else begin
			// A new result replaces one that is popped in the same cycle.
			if (state_q == S_DONE && load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					iter_q <= '0;
					if (!q_empty) begin
						state_q <= at_origin ? S_ERR : S_ITER;
					end
				end
				S_ITER: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: state_q <= S_MUL;
				S_MUL: state_q <= S_DONE;
				S_DONE: begin
					if (load_res) begin
						if (inband_q) begin
							turn_q <= '0;
							fwd_q  <= near_q ? 12'd0 : cfg.cruise_speed_mm_s;
						end else begin
							turn_q <= sat;
							fwd_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		stop_sq_q <= DIST_W'(cfg.stop_distance_mm) * DIST_W'(cfg.stop_distance_mm);
		if (q_pop) begin
			cx_q   <= px;
			cy_q   <= py;
			z_q    <= at_origin ? '0 : pz;
			near_q <= q_data.dist_sq < stop_sq_q;
		end else if (state_q == S_ITER) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + ysh;
				cy_q <= cy_q - xsh;
				z_q  <= z_q + lut;
			end else begin
				cx_q <= cx_q - ysh;
				cy_q <= cy_q + xsh;
				z_q  <= z_q - lut;
			end
		end
		if (state_q == S_ERR) begin
			err_q <= $signed(z_q - cfg.heading);
		end
		if (state_q == S_MUL) begin
			prod_q   <= 25'(err_q) * 25'($signed({1'b0, cfg.turn_gain_q8}));
			inband_q <= mag < {1'b0, cfg.aim_deadband};
		end
	end

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER) |-> (iter_q < ITER_W'(CORDIC_STEPS)))
		else $error("CORDIC step counter overran");

	a_result_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_valid_q && !res_pop) |=> (state_q == S_DONE))
		else $error("pending result overwritten");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == S_ITER || state_q == S_ERR))
		else $error("command taken outside idle");

endmodule

`default_nettype wire

/* hw/rtl/nearest_point_heading_steer_core.sv */
// Top level of the nearest-point heading steer block.
// Depends on npst_pkg, npst_cfg, npst_front, npst_cmd_fifo and npst_back.
//
// Usage. Points of a cloud are written like into a queue: an item is taken on a
// clock edge with push high and full low. Each word carries point_x, point_y
// (signed millimetres) and last_point, which closes the cloud. The front stage
// takes one point per cycle while full is low; it squares the distance in one stage
// and compares it with the squared capture radius and the current best in the next.
// When a cloud closes and some point lay strictly inside the capture radius,
// the nearest point goes into a two-entry command queue. The back stage then
// runs 16 shared CORDIC iterations, forms the heading error and multiplies it by
// the gain; the result word appears after the CORDIC, error and multiply steps (a
// point at the origin skips the CORDIC steps). A cloud with no qualifying point
// gives no result word. Throughput is one point per cycle within a cloud while
// full is low; the back handles one cloud at a time with its single iterative
// CORDIC unit, and the command queue absorbs short clouds. Results are read like
// from a queue: the word on turn_rate and forward_speed is valid while empty is
// low and is taken when pop is high. If the receiver stalls, the back holds its
// result, the command queue fills, and then full rises when the next closing
// point reaches the compare stage. Reset clears all control state and loads the
// register defaults; no clearing pass is needed. Registers are to be written over
// the APB port while the block is idle; the block itself does not enforce this.
`default_nettype none

module nearest_point_heading_steer_core import npst_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [PADDR_W-1:0]        paddr,
	input  wire logic [PDATA_W-1:0]        pwdata,
	output logic      [PDATA_W-1:0]        prdata,
	output logic                           pready,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic                      last_point,
	output logic                           empty,
	input  wire logic                      pop,
	output logic signed [15:0]             turn_rate,
	output logic        [11:0]             forward_speed
);

	cfg_t cfg;
	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic res_valid;

	// Register file, always ready.
	npst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Nearest-point search over the incoming cloud.
	npst_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.point_x           (point_x),
		.point_y           (point_y),
		.last_point        (last_point),
		.full              (full),
		.capture_radius_mm (cfg.capture_radius_mm),
		.q_full            (cmd_full),
		.q_push            (cmd_push),
		.q_data            (cmd_in)
	);

	// Decouples the point stream from the slow per-cloud work.
	npst_cmd_fifo u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd      (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	// Bearing, heading error and the command that follows from it.
	npst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_empty       (cmd_empty),
		.q_data        (cmd_out),
		.q_pop         (cmd_pop),
		.res_valid     (res_valid),
		.res_pop       (pop),
		.turn_rate     (turn_rate),
		.forward_speed (forward_speed)
	);

	assign empty = ~res_valid;

endmodule

`default_nettype wire
